@@ sv/mctt_pkg.sv @@
// types and codes shared by the tick timer bank
// no dependencies; used by every other file of the block
`default_nettype none

package mctt_pkg;

	// operation codes of an input item
	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_SETUP   = 3'd1,
		OP_START   = 3'd2,
		OP_STOP    = 3'd3,
		OP_DESTROY = 3'd4,
		OP_QUERY   = 3'd5
	} op_t;

	// timer status codes as seen on the result port
	typedef enum logic [2:0] {
		ST_UNUSED    = 3'd0,
		ST_CREATED   = 3'd1,
		ST_STARTED   = 3'd2,
		ST_STOPPED   = 3'd3,
		ST_DESTROYED = 3'd4
	} status_t;

	// result kind codes
	localparam logic KIND_FIRE  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// at most this many fire results per tick
	localparam int unsigned MAX_RESULTS = 8;
	localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);

	localparam int unsigned IDX_W = 3;
	localparam int unsigned FLD_W = 32;

	// decoded command broadcast to every cell
	typedef struct packed {
		logic              tick;
		logic              setup;
		logic              start;
		logic              stop;
		logic              destroy;
		logic              query;
		logic [IDX_W-1:0]  index;
		logic [FLD_W-1:0]  start_delay;
		logic [FLD_W-1:0]  period;
		logic              hard;
	} cmd_t;

	// scan control from the sequencer to the cells
	typedef struct packed {
		logic scan;
		logic group_hard;
		logic tok_ld;
		logic tok_clr;
	} scan_ctrl_t;

	// record passed down the cell chain
	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  which;
		status_t           status;
		logic [FLD_W-1:0]  delay;
		logic [FLD_W-1:0]  period;
		logic              hard;
	} rec_t;

endpackage

`default_nettype wire

@@ sv/mctt_cell.sv @@
// one timer cell: stored fields, countdown, status and the scan token stage
// depends on mctt_pkg
`default_nettype none

module mctt_cell #(
	parameter int unsigned TICK_WIDTH = 32,
	parameter int unsigned CELL_ID    = 0
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mctt_pkg::cmd_t         cmd,
	input  wire mctt_pkg::scan_ctrl_t   scan,
	input  wire logic                   tok_in,
	output logic                        tok_out,
	input  wire mctt_pkg::rec_t         bus_in,
	output mctt_pkg::rec_t              bus_out
);

	logic [TICK_WIDTH-1:0] delay_q;
	logic [TICK_WIDTH-1:0] period_q;
	logic [TICK_WIDTH-1:0] count_q;
	logic [TICK_WIDTH-1:0] new_delay;
	logic [TICK_WIDTH-1:0] new_period;
	logic                  hard_q;
	logic                  fired_q;
	logic                  tok_q;
	logic                  match;
	logic                  expire;
	logic                  sel;
	mctt_pkg::status_t     status_q;
	mctt_pkg::rec_t        mine;

	assign match      = (32'(cmd.index) == CELL_ID);
	assign new_delay  = TICK_WIDTH'(cmd.start_delay);
	assign new_period = TICK_WIDTH'(cmd.period);

	// count already zero, or reaches zero on this tick
	assign expire = (status_q == mctt_pkg::ST_STARTED) &&
		((count_q == '0) || (count_q == TICK_WIDTH'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= '0;
			period_q <= '0;
			count_q  <= '0;
			hard_q   <= 1'b0;
			fired_q  <= 1'b0;
			status_q <= mctt_pkg::ST_UNUSED;
		end else if (cmd.tick) begin
			fired_q <= expire;
			if (expire) begin
				if (period_q != '0)
					count_q <= period_q;
				else
					status_q <= mctt_pkg::ST_STOPPED;
			end else if (status_q == mctt_pkg::ST_STARTED) begin
				count_q <= count_q - TICK_WIDTH'(1);
			end
		end else if (match && cmd.setup) begin
			delay_q  <= new_delay;
			period_q <= new_period;
			hard_q   <= cmd.hard;
			count_q  <= (new_delay != '0) ? new_delay : new_period;
			status_q <= mctt_pkg::ST_CREATED;
		end else if (match && cmd.start) begin
			if (status_q == mctt_pkg::ST_CREATED || status_q == mctt_pkg::ST_STOPPED) begin
				count_q  <= (delay_q != '0) ? delay_q : period_q;
				status_q <= mctt_pkg::ST_STARTED;
			end
		end else if (match && cmd.stop) begin
			if (status_q == mctt_pkg::ST_STARTED)
				status_q <= mctt_pkg::ST_STOPPED;
		end else if (match && cmd.destroy) begin
			status_q <= mctt_pkg::ST_DESTROYED;
		end
	end

	// scan token moves one cell per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tok_q <= 1'b0;
		else if (scan.tok_clr)
			tok_q <= 1'b0;
		else if (scan.tok_ld)
			tok_q <= tok_in;
	end

	assign tok_out = tok_q;

	assign sel = (scan.scan && tok_q && fired_q && (hard_q == scan.group_hard)) ||
		(cmd.query && match);

	always_comb begin
		mine        = '0;
		mine.hit    = 1'b1;
		mine.which  = mctt_pkg::IDX_W'(CELL_ID);
		mine.status = status_q;
		mine.delay  = mctt_pkg::FLD_W'(delay_q);
		mine.period = mctt_pkg::FLD_W'(period_q);
		mine.hard   = hard_q;
	end

	assign bus_out = sel ? mine : bus_in;

endmodule

`default_nettype wire

@@ sv/mctt_ctrl.sv @@
// scan sequencer: token injection, hard/soft passes, fire holding stage
// and the result register; depends on mctt_pkg
`default_nettype none

module mctt_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 start,
	input  wire logic                 query,
	input  wire mctt_pkg::rec_t       bus,
	input  wire logic                 tok_last,
	output mctt_pkg::scan_ctrl_t      scan,
	output logic                      tok0_in,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      out_kind,
	output logic                      out_last,
	output mctt_pkg::rec_t            out_rec
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_HARD  = 4'b0010,
		S_SOFT  = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

	state_t                       state_q;
	state_t                       state_d;
	logic [mctt_pkg::CNT_W-1:0]   cnt_q;
	logic                         pend_v_q;
	mctt_pkg::rec_t               pend_q;
	logic                         out_valid_q;
	logic                         kind_q;
	logic                         last_q;
	mctt_pkg::rec_t               out_q;
	logic                         scanning;
	logic                         can_push;
	logic                         hit;
	logic                         step;
	logic                         cap;
	logic                         push_fire;
	logic                         push_last;

	assign scanning  = (state_q == S_HARD) || (state_q == S_SOFT);
	assign can_push  = !out_valid_q || out_ready;
	assign hit       = scanning && bus.hit;
	assign step      = scanning && (!(hit && pend_v_q) || can_push);
	assign cap       = hit && (cnt_q == mctt_pkg::CNT_W'(mctt_pkg::MAX_RESULTS - 1));
	assign push_last = (state_q == S_FLUSH);
	assign push_fire = (step && hit && pend_v_q) ||
		((state_q == S_FLUSH) && pend_v_q && can_push);

	assign in_ready = (state_q == S_IDLE) && can_push;

	assign scan.scan       = scanning;
	assign scan.group_hard = (state_q == S_HARD);
	assign scan.tok_ld     = step || start;
	assign scan.tok_clr    = (state_q == S_FLUSH);
	assign tok0_in         = start || ((state_q == S_HARD) && tok_last);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && start)
					state_d = S_HARD;
			end
			S_HARD: begin
				if (step && cap)
					state_d = S_FLUSH;
				else if (step && tok_last)
					state_d = S_SOFT;
			end
			S_SOFT: begin
				if (step && (cap || tok_last))
					state_d = S_FLUSH;
			end
			S_FLUSH: begin
				if (!pend_v_q || can_push)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start)
				cnt_q <= '0;
			else if (step && hit)
				cnt_q <= cnt_q + mctt_pkg::CNT_W'(1);
			if (step && hit)
				pend_v_q <= 1'b1;
			else if (push_fire && push_last)
				pend_v_q <= 1'b0;
		end
	end

	// the fire found last is held until the next one or the pass end
	always_ff @(posedge clk) begin
		if (step && hit)
			pend_q <= bus;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (push_fire || query)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			kind_q <= mctt_pkg::KIND_FIRE;
			last_q <= push_last;
			out_q  <= pend_q;
		end else if (query) begin
			kind_q <= mctt_pkg::KIND_QUERY;
			last_q <= 1'b1;
			out_q  <= bus;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;
	assign out_rec   = out_q;

endmodule

`default_nettype wire

@@ sv/multi_channel_tick_timer.sv @@
// top level of the tick timer bank: command decode, row of timer cells, scan sequencer
// depends on mctt_pkg, mctt_cell, mctt_ctrl
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  in      | to block  | in_valid / in_ready | op, timer_index, start_delay, period,
//          |           |                     | hard_type
//  out     | from block| out_valid/out_ready | kind, which_timer, timer_state,
//          |           |                     | stored_start_delay, stored_period,
//          |           |                     | stored_hard_type, last
//
// setup, start, stop and destroy update the addressed cell at their accept edge; a
// query item lands in the result register at its accept edge
// a tick updates all cells at its accept edge, then a token walks the cell row
// twice (hard pass, soft pass) at one cell per cycle, ending early once MAX_RESULTS
// fires are found; a flush state then sends out the held fire, if any, marked last
// a stalled output holds the walk only when a second fire must be moved out;
// no new item is taken during a walk or while the result register is blocked
// asynchronous reset clears every cell at once, no clearing pass is needed
`default_nettype none

module multi_channel_tick_timer #(
	parameter int unsigned TIMER_COUNT = 8,
	parameter int unsigned TICK_WIDTH  = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input item channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  op,
	input  wire logic [2:0]  timer_index,
	input  wire logic [31:0] start_delay,
	input  wire logic [31:0] period,
	input  wire logic        hard_type,
	// result item channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic [2:0]       which_timer,
	output logic [2:0]       timer_state,
	output logic [31:0]      stored_start_delay,
	output logic [31:0]      stored_period,
	output logic             stored_hard_type,
	output logic             last
);

	logic                 acc;
	mctt_pkg::op_t        op_c;
	mctt_pkg::cmd_t       cmd;
	mctt_pkg::scan_ctrl_t scan;
	logic                 tok0_in;
	logic                 out_kind;
	logic                 out_last;
	mctt_pkg::rec_t       out_rec;

	// token and record chains through the cell row
	logic                 tok_chain [TIMER_COUNT];
	mctt_pkg::rec_t       bus_chain [TIMER_COUNT+1];

	assign acc  = in_valid && in_ready;
	assign op_c = mctt_pkg::op_t'(op);

	// one strobe per accepted item, unknown codes fall through as no-ops
	always_comb begin
		cmd             = '0;
		cmd.index       = timer_index;
		cmd.start_delay = start_delay;
		cmd.period      = period;
		cmd.hard        = hard_type;
		unique case (op_c)
			mctt_pkg::OP_TICK:    cmd.tick    = acc;
			mctt_pkg::OP_SETUP:   cmd.setup   = acc;
			mctt_pkg::OP_START:   cmd.start   = acc;
			mctt_pkg::OP_STOP:    cmd.stop    = acc;
			mctt_pkg::OP_DESTROY: cmd.destroy = acc;
			mctt_pkg::OP_QUERY:   cmd.query   = acc;
			default: ;
		endcase
	end

	// an index with no cell behind it reads as an unused timer with zero fields
	assign bus_chain[0] = '{1'b0, timer_index, mctt_pkg::ST_UNUSED, 32'd0, 32'd0, 1'b0};

	genvar gi;
	generate
		for (gi = 0; gi < TIMER_COUNT; gi++) begin : g_cell
			logic tin;
			if (gi == 0) begin : g_head
				assign tin = tok0_in;
			end else begin : g_link
				assign tin = tok_chain[gi-1];
			end
			mctt_cell #(
				.TICK_WIDTH (TICK_WIDTH),
				.CELL_ID    (gi)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.cmd     (cmd),
				.scan    (scan),
				.tok_in  (tin),
				.tok_out (tok_chain[gi]),
				.bus_in  (bus_chain[gi]),
				.bus_out (bus_chain[gi+1])
			);
		end
	endgenerate

	mctt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.start     (cmd.tick),
		.query     (cmd.query),
		.bus       (bus_chain[TIMER_COUNT]),
		.tok_last  (tok_chain[TIMER_COUNT-1]),
		.scan      (scan),
		.tok0_in   (tok0_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_kind  (out_kind),
		.out_last  (out_last),
		.out_rec   (out_rec)
	);

	assign kind               = out_kind;
	assign last               = out_last;
	assign which_timer        = out_rec.which;
	assign timer_state        = out_rec.status;
	assign stored_start_delay = out_rec.delay;
	assign stored_period      = out_rec.period;
	assign stored_hard_type   = out_rec.hard;

endmodule

`default_nettype wire

@@ sv/mctt_checker.sv @@
// port-level checks for the tick timer bank, bound to the top level
// depends on mctt_pkg and multi_channel_tick_timer
`default_nettype none

module mctt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [2:0]  op,
	input wire logic [2:0]  timer_index,
	input wire logic [31:0] start_delay,
	input wire logic [31:0] period,
	input wire logic        hard_type,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        kind,
	input wire logic [2:0]  which_timer,
	input wire logic [2:0]  timer_state,
	input wire logic [31:0] stored_start_delay,
	input wire logic [31:0] stored_period,
	input wire logic        stored_hard_type,
	input wire logic        last
);

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(which_timer) &&
		$stable(kind) && $stable(last) && $stable(stored_period))
		else $error("result item changed while stalled");

	// a query item is answered by a single reply on the next cycle
	a_query_reply: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == mctt_pkg::OP_QUERY |=>
		out_valid && kind == mctt_pkg::KIND_QUERY && last)
		else $error("query item not answered");

	// a fired timer is left started or stopped
	a_fire_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == mctt_pkg::KIND_FIRE |->
		timer_state == mctt_pkg::ST_STARTED || timer_state == mctt_pkg::ST_STOPPED)
		else $error("fire reported with wrong timer state");

	// more fires of the same tick are pending, so no new item may enter
	a_busy_mid_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == mctt_pkg::KIND_FIRE && !last |-> !in_ready)
		else $error("item taken in the middle of a tick");

endmodule

bind multi_channel_tick_timer mctt_checker u_mctt_checker (.*);

`default_nettype wire
